[rtl/core/tir_pkg.sv]
// tir_pkg: shared types and constants for the tachometer interval-to-RPM block.
// Depends on nothing; imported by every module under rtl/core except tir_fifo.
`timescale 1ns / 1ps

package tir_pkg;

    localparam int          INTERVAL_BITS_DEF = 16;
    localparam int          TICKS_W           = 16;
    localparam int          TICK_US_W         = 8;
    localparam int          RPM_W             = 25;
    localparam int unsigned US_PER_SECOND     = 1000000;
    localparam int          QUOT_BITS         = $clog2(US_PER_SECOND + 1);
    localparam int          JOB_DEPTH         = 2;

    localparam logic [TICK_US_W-1:0] TICK_US_RESET = 8'd23;

    localparam logic CMD_CAPTURE = 1'b0;
    localparam logic CMD_REPORT  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ZERO  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } back_state_t;

    typedef struct packed {
        logic               cmd;
        logic [TICKS_W-1:0] interval_ticks;
    } in_t;

    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        status_t          status;
    } out_t;

endpackage

[rtl/core/tachometer_interval_to_rpm.sv]
// tachometer_interval_to_rpm: top level of the tach interval to RPM block.
// Depends on tir_pkg, tir_front, tir_fifo, tir_back.
`timescale 1ns / 1ps

// Channel | Direction | Payload          | Notes
// in      | sink      | tir_pkg::in_t    | cmd 0 capture interval, cmd 1 report
// out     | source    | tir_pkg::out_t   | one transaction per report
// cfg     | sink      | cfg_data[7:0]    | tick_us, always ready
//
// Captures update the min/max window in the front as they are accepted.
// A report's result passes through the job queue, the interval product, the restoring
// divide of one million (one quotient bit per cycle), then the scale by 60 and the
// load of the output register. Empty or zero reports skip the divide.
// Reset clears the window and sets tick_us to 23.
// in_ready drops only when the 2-deep job queue is full; out stalls hold the back.

module tachometer_interval_to_rpm #(
    parameter int INTERVAL_BITS = tir_pkg::INTERVAL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tir_pkg::in_t                  in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tir_pkg::out_t                 out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tir_pkg::TICK_US_W-1:0] cfg_data
);

    import tir_pkg::*;

    localparam int JOB_W = INTERVAL_BITS + 1;

    logic [TICK_US_W-1:0] tick_us_reg, tick_us_next;

    // front -> queue
    logic             fq_valid, fq_ready;
    logic [JOB_W-1:0] fq_data;
    // queue -> back
    logic             qb_valid, qb_ready;
    logic [JOB_W-1:0] qb_data;

    // configuration: always ready; the sender writes only while no report is in flight
    assign cfg_ready    = 1'b1;
    assign tick_us_next = (cfg_valid && cfg_ready) ? cfg_data : tick_us_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_us_reg <= TICK_US_RESET;
        end
        else
        begin
            tick_us_reg <= tick_us_next;
        end
    end

    tir_front #(
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job_data  (fq_data)
    );

    tir_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(JOB_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    tir_back #(
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_us   (tick_us_reg),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job_data  (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

[rtl/core/tir_fifo.sv]
// tir_fifo: small flop-based queue between front and back of the RPM block.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module tir_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fifo count above depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fifo count missed a push");

    a_count_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("fifo count missed a pop");
`endif

endmodule

[rtl/core/tir_front.sv]
// tir_front: takes input transactions, tracks the interval window and queues
// report jobs. Depends on tir_pkg.
`timescale 1ns / 1ps

module tir_front #(
    parameter int INTERVAL_BITS = tir_pkg::INTERVAL_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tir_pkg::in_t           in_item,
    output logic                   job_valid,
    input  logic                   job_ready,
    output logic [INTERVAL_BITS:0] job_data
);

    import tir_pkg::*;

    localparam int EXT_W = (INTERVAL_BITS > TICKS_W) ? INTERVAL_BITS : TICKS_W;

    logic [INTERVAL_BITS-1:0] longest_reg, longest_next;
    logic [INTERVAL_BITS-1:0] shortest_reg, shortest_next;
    logic [EXT_W-1:0]         ticks_ext;
    logic [INTERVAL_BITS-1:0] ticks;
    logic [INTERVAL_BITS:0]   sum;
    logic                     empty;
    logic                     accept;

    assign ticks_ext = EXT_W'(in_item.interval_ticks);
    assign ticks     = ticks_ext[INTERVAL_BITS-1:0];
    assign sum       = {1'b0, longest_reg} + {1'b0, shortest_reg};
    assign empty     = (longest_reg < shortest_reg);

    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = in_valid && (in_item.cmd == CMD_REPORT);
    // job: empty flag on top, average below
    assign job_data  = {empty, sum[INTERVAL_BITS:1]};

    always_comb
    begin
        longest_next  = longest_reg;
        shortest_next = shortest_reg;
        if (accept)
        begin
            if (in_item.cmd == CMD_REPORT)
            begin
                longest_next  = '0;
                shortest_next = '1;
            end
            else
            begin
                if (ticks > longest_reg)
                begin
                    longest_next = ticks;
                end
                if (ticks < shortest_reg)
                begin
                    shortest_next = ticks;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            longest_reg  <= '0;
            shortest_reg <= '1;
        end
        else
        begin
            longest_reg  <= longest_next;
            shortest_reg <= shortest_next;
        end
    end

endmodule

[rtl/core/tir_back.sv]
// tir_back: per-report arithmetic: revolution time product, serial divide of
// one million, times 60, output register. Depends on tir_pkg.
`timescale 1ns / 1ps

module tir_back #(
    parameter int INTERVAL_BITS = tir_pkg::INTERVAL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tir_pkg::TICK_US_W-1:0] tick_us,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  logic [INTERVAL_BITS:0]        job_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tir_pkg::out_t                 out_item
);

    import tir_pkg::*;

    localparam int PROD_W = INTERVAL_BITS + TICK_US_W;
    localparam int REV_W  = PROD_W + 1;
    localparam int CMP_W  = (REV_W > QUOT_BITS + 1) ? REV_W : QUOT_BITS + 1;
    localparam int CNT_W  = $clog2(QUOT_BITS);

    back_state_t              state_reg, state_next;
    logic [INTERVAL_BITS-1:0] avg_reg, avg_next;
    logic                     empty_reg, empty_next;
    logic [REV_W-1:0]         rev_reg, rev_next;
    logic [QUOT_BITS-1:0]     rem_reg, rem_next;
    logic [QUOT_BITS-1:0]     dvd_reg, dvd_next;
    logic [QUOT_BITS-1:0]     quot_reg, quot_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    status_t                  status_reg, status_next;
    logic                     out_valid_reg, out_valid_next;
    out_t                     out_reg, out_next;

    logic [PROD_W-1:0]        prod;
    logic [QUOT_BITS:0]       rem_shift;
    logic [CMP_W-1:0]         trial;
    logic [CMP_W-1:0]         divisor;
    logic [RPM_W-1:0]         rpm_val;
    logic                     slot_free;

    assign prod      = PROD_W'(avg_reg) * PROD_W'(tick_us);
    assign rem_shift = {rem_reg, dvd_reg[QUOT_BITS-1]};
    assign trial     = CMP_W'(rem_shift);
    assign divisor   = CMP_W'(rev_reg);
    // q * 60 = q * 64 - q * 4
    assign rpm_val   = (RPM_W'(quot_reg) << 6) - (RPM_W'(quot_reg) << 2);
    assign slot_free = !out_valid_reg || out_ready;

    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        avg_next       = avg_reg;
        empty_next     = empty_reg;
        rev_next       = rev_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    avg_next   = job_data[INTERVAL_BITS-1:0];
                    empty_next = job_data[INTERVAL_BITS];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                rev_next  = {prod, 1'b0};
                rem_next  = '0;
                dvd_next  = QUOT_BITS'(US_PER_SECOND);
                quot_next = '0;
                cnt_next  = '0;
                if (empty_reg)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_FIN;
                end
                else
                begin
                    status_next = ST_OK;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rev_reg == '0)
                begin
                    status_next = ST_ZERO;
                    state_next  = S_FIN;
                end
                else
                begin
                    // restoring divide, one quotient bit per cycle, MSB first
                    dvd_next = dvd_reg << 1;
                    if (trial >= divisor)
                    begin
                        rem_next  = QUOT_BITS'(trial - divisor);
                        quot_next = {quot_reg[QUOT_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = rem_shift[QUOT_BITS-1:0];
                        quot_next = {quot_reg[QUOT_BITS-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(QUOT_BITS - 1))
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_next.rpm    = (status_reg == ST_OK) ? rpm_val : '0;
                    out_next.status = status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg    <= avg_next;
        empty_reg  <= empty_next;
        rev_reg    <= rev_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        quot_reg   <= quot_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

`ifndef SYNTH
    a_err_rpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status != ST_OK) |-> out_reg.rpm == '0)
        else $error("nonzero rpm on error status");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (rev_reg != '0) |-> rem_reg < rev_reg)
        else $error("divider remainder not below divisor");

    a_fin_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && slot_free |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("finished report not written to output");
`endif

endmodule
